### sv/slmrb_pkg.sv
//------------------------------------------------------------------------------
// slmrb_pkg: shared types and constants for the strided layout basis block
// Holds widths, result kind codes and the controller/datapath command struct.
//------------------------------------------------------------------------------
`default_nettype none
package slmrb_pkg;
    localparam int DEF_MAX_DIMS = 8;
    localparam int SIZE_W   = 16;
    localparam int STRIDE_W = 32;
    localparam int PROD_W   = 48;
    localparam int POS_W    = 5;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_BASIS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // store incoming dimension
        logic sort_step;   // one insertion-sort compare/move
        logic walk_start;  // begin walking sorted dims
        logic div_start;   // start a stride / product division
        logic div_step;    // one division bit
        logic walk_commit; // commit basis entries of current dim
        logic clear;       // return layout state to reset values
    } slmrb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;        // MAX_DIMS dims already held
        logic overflow;
        logic sort_done;
        logic div_done;
        logic div_fail;    // product zero or remainder nonzero
        logic walk_done;
    } slmrb_sts_t;
endpackage
`default_nettype wire

### sv/slmrb_datapath.sv
//------------------------------------------------------------------------------
// slmrb_datapath: dimension store, insertion sort, serial divider and basis
// Executes controller commands; exposes basis and positions for readout.
//------------------------------------------------------------------------------
`default_nettype none
module slmrb_datapath
    import slmrb_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DIM_W    = $clog2(MAX_DIMS + 1),
    parameter int IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    parameter int BAS_W    = $clog2(2 * MAX_DIMS + 1),
    parameter int BIDX_W   = $clog2(2 * MAX_DIMS)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire slmrb_cmd_t          cmd,
    output slmrb_sts_t               sts,
    input  wire logic [SIZE_W-1:0]   dim_size,
    input  wire logic [STRIDE_W-1:0] dim_stride,
    input  wire logic [BIDX_W-1:0]   rd_basis_idx,
    output logic [STRIDE_W-1:0]      rd_basis,
    input  wire logic [IDX_W-1:0]    rd_dim_idx,
    output logic [BAS_W-1:0]         rd_dim_pos,
    output logic [BAS_W-1:0]         basis_len,
    output logic [DIM_W-1:0]         dim_count
);
    localparam int DIV_CNT_W = $clog2(STRIDE_W + 1);

    logic [SIZE_W-1:0]   size_mem   [MAX_DIMS];
    logic [STRIDE_W-1:0] stride_mem [MAX_DIMS];
    logic [IDX_W-1:0]    order_reg  [MAX_DIMS];
    logic [BAS_W-1:0]    posd_reg   [MAX_DIMS];
    logic [STRIDE_W-1:0] basis_mem  [2*MAX_DIMS];

    logic [DIM_W-1:0]    cnt_reg;
    logic                ovf_reg;
    logic [BAS_W-1:0]    len_reg;
    logic [PROD_W-1:0]   prod_reg;
    // insertion sort: i_reg outer, j_reg inner position
    logic [DIM_W-1:0]    i_reg;
    logic [DIM_W-1:0]    j_reg;
    logic                sdone_reg;
    // walk index
    logic [DIM_W-1:0]    w_reg;
    // serial restoring divider
    logic [STRIDE_W-1:0] quo_reg;
    logic [PROD_W:0]     rem_reg;
    logic [STRIDE_W-1:0] dvd_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    logic [IDX_W-1:0]    a_d, b_d, cur_d;
    logic                ahead;
    logic [STRIDE_W-1:0] eff_stride;
    logic [SIZE_W-1:0]   eff_size;
    logic [PROD_W:0]     rem_sh;
    logic                need_gap;
    logic [STRIDE_W+SIZE_W-1:0] fin_prod;

    // element being inserted is kept at order slot j; compare to slot j-1
    assign a_d = order_reg[j_reg[IDX_W-1:0]];
    assign b_d = order_reg[IDX_W'(j_reg - DIM_W'(1))];
    always_comb
    begin
        if (stride_mem[a_d] != stride_mem[b_d])
            ahead = stride_mem[a_d] < stride_mem[b_d];
        else if (size_mem[a_d] != size_mem[b_d])
            ahead = size_mem[a_d] < size_mem[b_d];
        else
            ahead = a_d < b_d;
    end

    assign cur_d      = order_reg[w_reg[IDX_W-1:0]];
    assign eff_stride = (stride_mem[cur_d] == '0) ? STRIDE_W'(1) : stride_mem[cur_d];
    assign eff_size   = (stride_mem[cur_d] == '0) ? SIZE_W'(1) : size_mem[cur_d];
    assign rem_sh     = {rem_reg[PROD_W-1:0], dvd_reg[STRIDE_W-1]};
    assign need_gap   = {16'd0, eff_stride} != prod_reg;
    // a committed dim divides evenly, so product times gap is the stride itself
    assign fin_prod   = eff_stride * eff_size;

    assign sts.full      = cnt_reg == DIM_W'(MAX_DIMS);
    assign sts.overflow  = ovf_reg;
    assign sts.sort_done = sdone_reg;
    assign sts.div_done  = dcnt_reg == '0;
    assign sts.div_fail  = (prod_reg == '0) || (rem_reg != '0);
    assign sts.walk_done = w_reg == cnt_reg;

    assign basis_len = len_reg;
    assign dim_count = cnt_reg;
    assign rd_basis   = basis_mem[rd_basis_idx];
    assign rd_dim_pos = len_reg - posd_reg[rd_dim_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            prod_reg  <= PROD_W'(1);
            len_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            sdone_reg <= 1'b0;
            w_reg     <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (sts.full)
                    ovf_reg <= 1'b1;
                else
                begin
                    cnt_reg <= cnt_reg + DIM_W'(1);
                    // a freshly loaded dim starts sorting at its own slot
                end
                i_reg     <= '0;
                j_reg     <= '0;
                sdone_reg <= 1'b0;
            end
            if (cmd.sort_step)
            begin
                if (i_reg == cnt_reg)
                    sdone_reg <= 1'b1;
                else if (j_reg != '0 && ahead)
                    j_reg <= j_reg - DIM_W'(1);
                else
                begin
                    i_reg <= i_reg + DIM_W'(1);
                    j_reg <= i_reg + DIM_W'(1);
                end
            end
            if (cmd.walk_start)
            begin
                w_reg    <= '0;
                len_reg  <= '0;
                prod_reg <= PROD_W'(1);
            end
            if (cmd.div_start)
            begin
                dvd_reg  <= eff_stride;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= DIV_CNT_W'(STRIDE_W);
            end
            if (cmd.div_step)
            begin
                dvd_reg  <= {dvd_reg[STRIDE_W-2:0], 1'b0};
                dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
                if (rem_sh >= {1'b0, prod_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, prod_reg};
                    quo_reg <= {quo_reg[STRIDE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[STRIDE_W-2:0], 1'b0};
                end
            end
            if (cmd.walk_commit)
            begin
                len_reg  <= len_reg + (need_gap ? BAS_W'(2) : BAS_W'(1));
                prod_reg <= fin_prod[PROD_W-1:0];
                w_reg    <= w_reg + DIM_W'(1);
            end
            if (cmd.clear)
            begin
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
                prod_reg <= PROD_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !sts.full)
        begin
            size_mem[cnt_reg[IDX_W-1:0]]   <= dim_size;
            stride_mem[cnt_reg[IDX_W-1:0]] <= dim_stride;
        end
        if (cmd.sort_step && i_reg != cnt_reg)
        begin
            if (j_reg != '0 && ahead)
            begin
                // swap inserted dim one slot down
                order_reg[j_reg[IDX_W-1:0]]              <= b_d;
                order_reg[IDX_W'(j_reg - DIM_W'(1))]     <= a_d;
            end
            else if (i_reg + DIM_W'(1) < cnt_reg)
                order_reg[IDX_W'(i_reg + DIM_W'(1))] <= IDX_W'(i_reg + DIM_W'(1));
        end
        if (cmd.load)
            order_reg[0] <= '0;
        if (cmd.walk_commit)
        begin
            if (need_gap)
            begin
                basis_mem[len_reg[BIDX_W-1:0]]              <= quo_reg;
                basis_mem[BIDX_W'(len_reg + BAS_W'(1))]     <= 32'(eff_size);
                posd_reg[cur_d] <= len_reg + BAS_W'(1);
            end
            else
            begin
                basis_mem[len_reg[BIDX_W-1:0]] <= 32'(eff_size);
                posd_reg[cur_d] <= len_reg;
            end
        end
    end
endmodule
`default_nettype wire

### sv/slmrb_ctrl.sv
//------------------------------------------------------------------------------
// slmrb_ctrl: sequencer for load, sort, divide/walk and result readout
// Drives datapath commands and the output register.
//------------------------------------------------------------------------------
`default_nettype none
module slmrb_ctrl
    import slmrb_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DIM_W    = $clog2(MAX_DIMS + 1),
    parameter int IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    parameter int BAS_W    = $clog2(2 * MAX_DIMS + 1),
    parameter int BIDX_W   = $clog2(2 * MAX_DIMS)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                last_dim,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [KIND_W-1:0]        result_kind,
    output logic [POS_W-1:0]         position,
    output logic [STRIDE_W-1:0]      value,
    output logic                     last,
    output slmrb_cmd_t               cmd,
    input  wire slmrb_sts_t          sts,
    output logic [BIDX_W-1:0]        rd_basis_idx,
    input  wire logic [STRIDE_W-1:0] rd_basis,
    output logic [IDX_W-1:0]         rd_dim_idx,
    input  wire logic [BAS_W-1:0]    rd_dim_pos,
    input  wire logic [BAS_W-1:0]    basis_len,
    input  wire logic [DIM_W-1:0]    dim_count
);
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_DIVS = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_COMM = 3'd4;
    localparam logic [2:0] ST_EMB  = 3'd5;
    localparam logic [2:0] ST_EMD  = 3'd6;
    localparam logic [2:0] ST_FAIL = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [BAS_W-1:0] k_reg, k_next;
    logic             ov_reg, ov_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [STRIDE_W-1:0] val_reg, val_next;
    logic             lst_reg, lst_next;
    logic             slot_free;

    assign slot_free   = !ov_reg || !out_stall;
    assign out_valid   = ov_reg;
    assign result_kind = kind_reg;
    assign position    = pos_reg;
    assign value       = val_reg;
    assign last        = lst_reg;
    assign in_stall    = state_reg != ST_LOAD;
    assign rd_basis_idx = BIDX_W'(basis_len - BAS_W'(1) - k_reg);
    assign rd_dim_idx   = k_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && out_stall;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        lst_next   = lst_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_dim)
                        state_next = (sts.overflow || sts.full) ? ST_FAIL : ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (sts.sort_done)
                begin
                    cmd.walk_start = 1'b1;
                    state_next = ST_DIVS;
                end
                else
                    cmd.sort_step = 1'b1;
            end
            ST_DIVS:
            begin
                if (sts.walk_done)
                begin
                    k_next = '0;
                    state_next = ST_EMB;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = sts.div_fail ? ST_FAIL : ST_COMM;
                else
                    cmd.div_step = 1'b1;
            end
            ST_COMM:
            begin
                cmd.walk_commit = 1'b1;
                state_next = ST_DIVS;
            end
            ST_EMB:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    kind_next = KIND_BASIS;
                    pos_next  = POS_W'(k_reg);
                    val_next  = rd_basis;
                    lst_next  = 1'b0;
                    if (k_reg + BAS_W'(1) == basis_len)
                    begin
                        k_next = '0;
                        state_next = ST_EMD;
                    end
                    else
                        k_next = k_reg + BAS_W'(1);
                end
            end
            ST_EMD:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    kind_next = KIND_DIM;
                    pos_next  = POS_W'(k_reg);
                    val_next  = STRIDE_W'(rd_dim_pos);
                    lst_next  = BAS_W'(dim_count) == k_reg + BAS_W'(1);
                    k_next    = k_reg + BAS_W'(1);
                    if (lst_next)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FAIL:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    kind_next = KIND_FAIL;
                    pos_next  = '0;
                    val_next  = '0;
                    lst_next  = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        lst_reg  <= lst_next;
    end
endmodule
`default_nettype wire

### sv/strided_layout_to_mixed_radix_basis.sv
// Dimension beats are stored as they arrive; after the final beat the dims are
//   insertion-sorted, then each passes through the serial stride/product
//   divider and a commit, and then the result beats are emitted.
// Throughput: one dimension beat per cycle while loading; one layout at a time.
// Reset: rst_n is asynchronous, active low; clears the sequencer, dimension
//   count, overflow flag and running product. Stores hold garbage until written.
//------------------------------------------------------------------------------
// strided_layout_to_mixed_radix_basis: strided layout to mixed-radix basis
// Collects dims, sorts them, divides out gaps and emits the reversed basis.
//------------------------------------------------------------------------------
`default_nettype none
module strided_layout_to_mixed_radix_basis
    import slmrb_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [SIZE_W-1:0]   dim_size,
    input  wire logic [STRIDE_W-1:0] dim_stride,
    input  wire logic                last_dim,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [KIND_W-1:0]        result_kind,
    output logic [POS_W-1:0]         position,
    output logic [STRIDE_W-1:0]      value,
    output logic                     last
);
    localparam int DIM_W  = $clog2(MAX_DIMS + 1);
    localparam int IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int BAS_W  = $clog2(2 * MAX_DIMS + 1);
    localparam int BIDX_W = $clog2(2 * MAX_DIMS);

    slmrb_cmd_t          cmd;
    slmrb_sts_t          sts;
    logic [BIDX_W-1:0]   rd_basis_idx;
    logic [STRIDE_W-1:0] rd_basis;
    logic [IDX_W-1:0]    rd_dim_idx;
    logic [BAS_W-1:0]    rd_dim_pos;
    logic [BAS_W-1:0]    basis_len;
    logic [DIM_W-1:0]    dim_count;

    // sequencer: holds the input while sorting, dividing and emitting
    slmrb_ctrl #(.MAX_DIMS(MAX_DIMS), .DIM_W(DIM_W), .IDX_W(IDX_W),
                 .BAS_W(BAS_W), .BIDX_W(BIDX_W)) u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .last_dim(last_dim),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .position(position), .value(value), .last(last),
        .cmd(cmd), .sts(sts),
        .rd_basis_idx(rd_basis_idx), .rd_basis(rd_basis),
        .rd_dim_idx(rd_dim_idx), .rd_dim_pos(rd_dim_pos),
        .basis_len(basis_len), .dim_count(dim_count)
    );

    // datapath: stores, sorter, divider and basis table
    slmrb_datapath #(.MAX_DIMS(MAX_DIMS), .DIM_W(DIM_W), .IDX_W(IDX_W),
                     .BAS_W(BAS_W), .BIDX_W(BIDX_W)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .dim_size(dim_size), .dim_stride(dim_stride),
        .rd_basis_idx(rd_basis_idx), .rd_basis(rd_basis),
        .rd_dim_idx(rd_dim_idx), .rd_dim_pos(rd_dim_pos),
        .basis_len(basis_len), .dim_count(dim_count)
    );
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb: self-checking bench for strided_layout_to_mixed_radix_basis
// Feeds layouts of dimensions, mostly well-formed with random content and some
// noise, computes the expected basis and dimension positions in a local
// predictor, and checks every output beat in order. Both sides idle at random.
//------------------------------------------------------------------------------
module tb;
    import slmrb_pkg::*;

    localparam int MAX_DIMS     = DEF_MAX_DIMS;
    localparam int BASIS_DEPTH  = 2 * MAX_DIMS;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 30;
    localparam int TARGET_ITEMS = 250;

    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [STRIDE_W-1:0] stride;
        logic                last;
    } dim_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [POS_W-1:0]    pos;
        logic [STRIDE_W-1:0] val;
        logic                last;
    } result_beat_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SIZE_W-1:0]   dim_size;
    logic [STRIDE_W-1:0] dim_stride;
    logic                last_dim;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   result_kind;
    logic [POS_W-1:0]    position;
    logic [STRIDE_W-1:0] value;
    logic                last;

    dim_beat_t    pending_dims[$];
    result_beat_t expected_results[$];

    // predictor copy of the layout being collected
    logic [SIZE_W-1:0]   held_size[MAX_DIMS];
    logic [STRIDE_W-1:0] held_stride[MAX_DIMS];
    int                  held_count;
    bit                  held_overflow;

    int errors;
    int dims_accepted;
    int results_seen;
    int layouts_done;
    int layouts_failed;
    int idle_cycles;
    int send_gap;
    int recv_stall_left;
    bit hold_done;

    strided_layout_to_mixed_radix_basis #(.MAX_DIMS(MAX_DIMS)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .dim_size    (dim_size),
        .dim_stride  (dim_stride),
        .last_dim    (last_dim),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .position    (position),
        .value       (value),
        .last        (last)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Order dimensions by stride, then size, then dimension number.
    function automatic bit sorts_ahead(int a, int b);
        if (held_stride[a] != held_stride[b])
            return held_stride[a] < held_stride[b];
        if (held_size[a] != held_size[b])
            return held_size[a] < held_size[b];
        return a < b;
    endfunction

    // Append one beat to the expected stream.
    function automatic void add_result(result_beat_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void push_failure();
        result_beat_t r;
        r.kind = KIND_FAIL;
        r.pos  = '0;
        r.val  = '0;
        r.last = 1'b1;
        add_result(r);
        layouts_failed++;
    endfunction

    // Take one dimension beat; on the final one, derive the whole result run.
    function automatic void absorb_dim(dim_beat_t d);
        int          order[MAX_DIMS];
        int          slot_of_dim[MAX_DIMS];
        logic [31:0] basis[BASIS_DEPTH];
        logic [63:0] product;
        logic [63:0] stride;
        logic [63:0] extent;
        logic [63:0] gap;
        int          len;
        int          j;
        int          dim;
        bit          failed;
        result_beat_t r;

        if (held_count < MAX_DIMS) begin
            held_size[held_count]   = d.size;
            held_stride[held_count] = d.stride;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (!d.last)
            return;

        layouts_done++;
        failed = held_overflow;
        if (!failed) begin
            for (int i = 0; i < held_count; i++) begin
                j = i;
                while (j > 0 && sorts_ahead(i, order[j-1])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            product = 64'd1;
            len = 0;
            for (int i = 0; i < held_count && !failed; i++) begin
                dim    = order[i];
                stride = held_stride[dim];
                extent = held_size[dim];
                // broadcast: stride zero behaves as stride one, size one
                if (stride == 0) begin
                    stride = 64'd1;
                    extent = 64'd1;
                end
                if (product == 0 || stride % product != 0) begin
                    failed = 1'b1;
                end else begin
                    if (stride != product) begin
                        gap = stride / product;
                        basis[len] = gap[31:0];
                        len++;
                        product = (product * gap) & 64'hFFFF_FFFF_FFFF;
                    end
                    basis[len] = extent[31:0];
                    slot_of_dim[dim] = len;
                    len++;
                    product = (product * extent) & 64'hFFFF_FFFF_FFFF;
                end
            end
        end

        if (failed) begin
            push_failure();
        end else begin
            for (int i = 0; i < len; i++) begin
                r.kind = KIND_BASIS;
                r.pos  = i[POS_W-1:0];
                r.val  = basis[len-1-i];
                r.last = 1'b0;
                add_result(r);
            end
            for (int i = 0; i < held_count; i++) begin
                r.kind = KIND_DIM;
                r.pos  = i[POS_W-1:0];
                r.val  = len - slot_of_dim[i];
                r.last = (i + 1 == held_count);
                add_result(r);
            end
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    function automatic void queue_dim(int unsigned size, int unsigned stride, bit fin);
        dim_beat_t d;
        d.size   = size[SIZE_W-1:0];
        d.stride = stride;
        d.last   = fin;
        pending_dims = {pending_dims, d};
    endfunction

    // Build a layout that the block can factor, then shuffle its dimensions.
    function automatic void queue_good_layout();
        int unsigned sizes[MAX_DIMS];
        int unsigned strides[MAX_DIMS];
        logic [63:0] product;
        logic [63:0] gap;
        logic [63:0] extent;
        int          n;
        int          k;
        int unsigned tmp;

        n = $urandom_range(1, MAX_DIMS);
        product = 64'd1;
        for (int i = 0; i < n; i++) begin
            extent = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 1) == 0) ? 64'd1 : $urandom_range(2, 9);
            if (product * gap * extent >= 64'h1_0000_0000) begin
                gap    = 64'd1;
                extent = 64'd1;
            end
            strides[i] = product * gap;
            sizes[i]   = extent;
            product    = product * gap * extent;
            if ($urandom_range(0, 11) == 0) begin
                // broadcast dim, sorted first, leaves the product alone
                strides[i] = 0;
                sizes[i]   = $urandom_range(0, 65535);
            end
        end
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = sizes[i];   sizes[i]   = sizes[k];   sizes[k]   = tmp;
            tmp = strides[i]; strides[i] = strides[k]; strides[k] = tmp;
        end
        for (int i = 0; i < n; i++)
            queue_dim(sizes[i], strides[i], i == n - 1);
    endfunction

    // Random content: full-range fields, possibly too many dimensions.
    function automatic void queue_noise_layout();
        int n;
        n = $urandom_range(1, MAX_DIMS + 3);
        for (int i = 0; i < n; i++)
            queue_dim($urandom_range(0, 65535), $urandom(), i == n - 1);
    endfunction

    // idle draw: calm stretches alternate with busy ones
    function automatic int draw_idle(int count);
        if ((count / 40) % 3 == 2)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // Driver: present beats from the pending queue, idle between them at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            dim_size   <= '0;
            dim_stride <= '0;
            last_dim   <= 1'b0;
            send_gap   <= 0;
        end else if (in_valid && !in_stall) begin
            absorb_dim('{dim_size, dim_stride, last_dim});
            dims_accepted++;
            if (pending_dims.size() != 0 && draw_idle(dims_accepted) == 0) begin
                {dim_size, dim_stride, last_dim} <= pending_dims.pop_front();
            end else begin
                in_valid <= 1'b0;
                send_gap <= draw_idle(dims_accepted);
            end
        end else if (!in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_dims.size() != 0) begin
                {dim_size, dim_stride, last_dim} <= pending_dims.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor: check each accepted beat, stall at random; hold off once for a
    // long stretch so the block backs up into its input.
    always @(posedge clk or negedge rst_n) begin
        result_beat_t want;
        int           wait_cycles;
        if (!rst_n) begin
            out_stall       <= 1'b0;
            recv_stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected beat kind=%0d pos=%0d value=%0h last=%0b",
                         $time, result_kind, position, value, last);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.kind !== result_kind || want.pos !== position ||
                    want.val !== value || want.last !== last) begin
                    $display("%0t: mismatch expected kind=%0d pos=%0d value=%0h last=%0b",
                             $time, want.kind, want.pos, want.val, want.last);
                    $display("%0t:          actual   kind=%0d pos=%0d value=%0h last=%0b",
                             $time, result_kind, position, value, last);
                    errors++;
                end
            end
            results_seen++;
            wait_cycles = draw_idle(results_seen);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                wait_cycles = HOLD_CYCLES;
            end
            recv_stall_left <= wait_cycles;
            out_stall <= (wait_cycles != 0);
        end else if (recv_stall_left > 0) begin
            recv_stall_left <= recv_stall_left - 1;
            out_stall <= (recv_stall_left != 1);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors         = 0;
        dims_accepted  = 0;
        results_seen   = 0;
        layouts_done   = 0;
        layouts_failed = 0;
        idle_cycles    = 0;
        held_count     = 0;
        held_overflow  = 1'b0;
        hold_done      = 1'b0;
        rst_n          = 1'b0;

        // directed layouts
        queue_dim(1, 1, 1);                            // trivial single dim
        queue_dim(65535, 32'hFFFF_FFFF, 1);            // extremes, huge gap
        queue_dim(3, 1, 0); queue_dim(5, 4, 1);        // stride not a multiple
        queue_dim(0, 1, 0); queue_dim(2, 2, 1);        // zero size, then fails
        queue_dim(0, 1, 1);                            // zero size alone
        queue_dim(7, 0, 0); queue_dim(4, 2, 1);        // broadcast plus gap
        queue_dim(1, 6, 0); queue_dim(1, 6, 0);        // equal stride and size
        queue_dim(6, 1, 1);
        for (int i = 0; i < MAX_DIMS + 1; i++)         // one dim too many
            queue_dim(1, 1, i == MAX_DIMS);
        for (int i = 0; i < MAX_DIMS; i++)             // exactly full, reversed
            queue_dim(2, 1 << (MAX_DIMS - 1 - i), i == MAX_DIMS - 1);

        while (pending_dims.size() < TARGET_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                queue_noise_layout();
            else
                queue_good_layout();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_dims.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d dimension beats in %0d layouts (%0d expected to fail).",
                 dims_accepted, layouts_done, layouts_failed);
        $display("Checked %0d result beats, %0d errors.", results_seen, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
sv/slmrb_pkg.sv
sv/slmrb_datapath.sv
sv/slmrb_ctrl.sv
sv/strided_layout_to_mixed_radix_basis.sv
tb/tb.sv
